/* design/lpd_pkg.sv */
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants for the length-prefixed deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package lpd_pkg;

  // Header layout: type, version, four length bytes (least significant first)
  localparam int unsigned HDR_BYTES   = 6;
  localparam int unsigned HDR_IDX_W   = 3;
  localparam int unsigned LEN_W       = 32;
  localparam int unsigned BYTE_W      = 8;

  localparam logic [HDR_IDX_W-1:0] IDX_TYPE    = 3'd0;
  localparam logic [HDR_IDX_W-1:0] IDX_VERSION = 3'd1;
  localparam logic [HDR_IDX_W-1:0] IDX_LEN0    = 3'd2;
  localparam logic [HDR_IDX_W-1:0] IDX_LEN1    = 3'd3;
  localparam logic [HDR_IDX_W-1:0] IDX_LEN2    = 3'd4;
  localparam logic [HDR_IDX_W-1:0] IDX_LEN3    = 3'd5;

  // Result kinds
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_BODY   = 1'b1;

  // Request queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [LEN_W-1:0]  len_t;

  // One classified request from the front part
  typedef struct packed {
    logic  kind;
    byte_t frame_type;
    byte_t frame_version;
    len_t  frame_length;
    byte_t raw_byte;
    logic  last;
  } cmd_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

`default_nettype wire

/* design/lpd_if.sv */
// ----------------------------------------------------------------------------
// lpd_if
// Valid/ready channels for the deframer: byte input and result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpd_in_if;
  logic                valid;
  logic                ready;
  lpd_pkg::byte_t      rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpd_out_if;
  logic                valid;
  logic                ready;
  logic                item_kind;
  lpd_pkg::byte_t      frame_type;
  lpd_pkg::byte_t      frame_version;
  lpd_pkg::len_t       frame_length;
  lpd_pkg::byte_t      payload_byte;
  logic                end_of_frame;

  modport source (output valid, output item_kind, output frame_type,
                  output frame_version, output frame_length,
                  output payload_byte, output end_of_frame, input ready);
  modport sink   (input valid, input item_kind, input frame_type,
                  input frame_version, input frame_length,
                  input payload_byte, input end_of_frame, output ready);
endinterface

`default_nettype wire

/* design/length_prefixed_deframer_core.sv */
// ----------------------------------------------------------------------------
// length_prefixed_deframer_core
// Split bytes into length-prefixed messages, a byte per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one stream byte per request (rx_byte), valid/ready handshake.
//   out_ch : one result per request: a header result when the sixth header
//            byte (type, version, 32-bit little-endian length) arrives, then
//            one body result per body byte, each repeating the header fields.
//            end_of_frame marks the result that completes a message; an empty
//            body puts it on the header result. Partial headers give nothing.
//   Throughput: one byte per cycle sustained; the front part takes a byte
//   every cycle the request queue has room.
//   Path: an accepted byte is written into the request queue, then loaded
//   into the output register, which drives out_ch.valid.
//   Reset (rst_n low, synchronous): framing returns to expecting a header
//   and the queue and output register are emptied.
//   Receiver stall: the output register holds its result, the four-entry
//   queue fills behind it, and in_ch.ready drops only once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_deframer_core (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lpd_in_if.sink      in_ch,
  lpd_out_if.source   out_ch
);

  lpd_pkg::qstat_t qstat;
  lpd_pkg::cmd_t   push_cmd;
  lpd_pkg::cmd_t   head_cmd;
  logic            push;
  logic            pop;

  // Front: accept and classify bytes
  lpd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_ch.valid),
    .rx_byte    (in_ch.rx_byte),
    .byte_ready (in_ch.ready),
    .qstat      (qstat),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // Queue: decouple the two sides so each may stall on its own
  lpd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .qstat    (qstat)
  );

  // Back: format results and hold them for the receiver
  lpd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .qstat    (qstat),
    .head_cmd (head_cmd),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

/* design/lpd_front.sv */
// ----------------------------------------------------------------------------
// lpd_front
// Accept stream bytes, track header/body framing and classify each byte.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             byte_valid,
  input  wire lpd_pkg::byte_t   rx_byte,
  output logic                  byte_ready,
  input  wire lpd_pkg::qstat_t  qstat,
  output logic                  push,
  output lpd_pkg::cmd_t         push_cmd
);

  logic                               in_body_r, in_body_nxt;
  logic [lpd_pkg::HDR_IDX_W-1:0]      hdr_idx_r, hdr_idx_nxt;
  lpd_pkg::byte_t                     type_r, type_nxt;
  lpd_pkg::byte_t                     version_r, version_nxt;
  lpd_pkg::len_t                      length_r, length_nxt;
  lpd_pkg::len_t                      left_r, left_nxt;

  logic                               accept;
  logic [lpd_pkg::HDR_IDX_W-1:0]      idx_eff;
  logic                               body_byte;
  logic                               produce;
  logic                               last;
  logic                               hdr_done;

  assign byte_ready = !qstat.full;
  assign accept     = byte_valid && byte_ready;
  assign body_byte  = in_body_r && (left_r != '0);
  // Out-of-range index restarts the header
  assign idx_eff    = (hdr_idx_r >= lpd_pkg::HDR_IDX_W'(lpd_pkg::HDR_BYTES))
                      ? lpd_pkg::IDX_TYPE : hdr_idx_r;
  assign hdr_done   = (idx_eff == lpd_pkg::IDX_LEN3);

  always_comb begin
    in_body_nxt = in_body_r;
    hdr_idx_nxt = hdr_idx_r;
    type_nxt    = type_r;
    version_nxt = version_r;
    length_nxt  = length_r;
    left_nxt    = left_r;
    produce     = 1'b0;
    last        = 1'b0;
    if (body_byte) begin
      left_nxt = left_r - 1'b1;
      produce  = 1'b1;
      last     = (left_r == lpd_pkg::LEN_W'(1));
      if (last) begin
        in_body_nxt = 1'b0;
        hdr_idx_nxt = lpd_pkg::IDX_TYPE;
      end
    end else begin
      in_body_nxt = 1'b0;
      unique case (idx_eff)
        lpd_pkg::IDX_TYPE:    type_nxt            = rx_byte;
        lpd_pkg::IDX_VERSION: version_nxt         = rx_byte;
        lpd_pkg::IDX_LEN0:    length_nxt[7:0]     = rx_byte;
        lpd_pkg::IDX_LEN1:    length_nxt[15:8]    = rx_byte;
        lpd_pkg::IDX_LEN2:    length_nxt[23:16]   = rx_byte;
        lpd_pkg::IDX_LEN3:    length_nxt[31:24]   = rx_byte;
        default:              type_nxt            = rx_byte;
      endcase
      hdr_idx_nxt = idx_eff + 1'b1;
      if (hdr_done) begin
        hdr_idx_nxt = lpd_pkg::IDX_TYPE;
        produce     = 1'b1;
        if (length_nxt == '0) begin
          last = 1'b1;
        end else begin
          in_body_nxt = 1'b1;
          left_nxt    = length_nxt;
        end
      end
    end
  end

  assign push                   = accept && produce;
  assign push_cmd.kind          = body_byte ? lpd_pkg::KIND_BODY : lpd_pkg::KIND_HEADER;
  assign push_cmd.frame_type    = type_nxt;
  assign push_cmd.frame_version = version_nxt;
  assign push_cmd.frame_length  = length_nxt;
  assign push_cmd.raw_byte      = rx_byte;
  assign push_cmd.last          = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_body_r <= 1'b0;
      hdr_idx_r <= lpd_pkg::IDX_TYPE;
      type_r    <= '0;
      version_r <= '0;
      length_r  <= '0;
      left_r    <= '0;
    end else if (accept) begin
      in_body_r <= in_body_nxt;
      hdr_idx_r <= hdr_idx_nxt;
      type_r    <= type_nxt;
      version_r <= version_nxt;
      length_r  <= length_nxt;
      left_r    <= left_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/lpd_queue.sv */
// ----------------------------------------------------------------------------
// lpd_queue
// Short request queue decoupling the front part from the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire lpd_pkg::cmd_t    push_cmd,
  input  wire logic             pop,
  output lpd_pkg::cmd_t         head_cmd,
  output lpd_pkg::qstat_t       qstat
);

  lpd_pkg::cmd_t                  entry_r [lpd_pkg::QUEUE_DEPTH];
  logic [lpd_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [lpd_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [lpd_pkg::QCNT_W-1:0]     count_r, count_nxt;
  logic                           do_push;
  logic                           do_pop;

  assign qstat.full  = (count_r == lpd_pkg::QCNT_W'(lpd_pkg::QUEUE_DEPTH));
  assign qstat.empty = (count_r == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head_cmd    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + lpd_pkg::QCNT_W'(do_push) - lpd_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

/* design/lpd_back.sv */
// ----------------------------------------------------------------------------
// lpd_back
// Format queued requests into results and hold them in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lpd_pkg::qstat_t  qstat,
  input  wire lpd_pkg::cmd_t    head_cmd,
  output logic                  pop,
  lpd_out_if.source             out_ch
);

  logic            valid_r;
  logic            kind_r;
  lpd_pkg::byte_t  type_r;
  lpd_pkg::byte_t  version_r;
  lpd_pkg::len_t   length_r;
  lpd_pkg::byte_t  payload_r;
  logic            last_r;
  lpd_pkg::byte_t  payload_nxt;

  // Advance when the output register is free or being drained
  assign pop = !qstat.empty && (!valid_r || out_ch.ready);

  // Header results carry a zero payload
  assign payload_nxt = (head_cmd.kind == lpd_pkg::KIND_BODY) ? head_cmd.raw_byte : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r    <= head_cmd.kind;
      type_r    <= head_cmd.frame_type;
      version_r <= head_cmd.frame_version;
      length_r  <= head_cmd.frame_length;
      payload_r <= payload_nxt;
      last_r    <= head_cmd.last;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.item_kind     = kind_r;
  assign out_ch.frame_type    = type_r;
  assign out_ch.frame_version = version_r;
  assign out_ch.frame_length  = length_r;
  assign out_ch.payload_byte  = payload_r;
  assign out_ch.end_of_frame  = last_r;

endmodule

`default_nettype wire
